[sv/atim_pkg.sv]
// Shared types, constants and a helper function for the axis transpose index map.
`default_nettype none

package atim_pkg;

	// Field and register widths.
	localparam int INDEX_W = 32;
	localparam int LEN_W   = 16;
	localparam int SPAN_W  = 3;
	localparam int NUM_LEN = 6;

	// Span limits: the span always holds at least two and at most six axes.
	localparam logic [SPAN_W-1:0] SPAN_MIN = SPAN_W'(2);
	localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(NUM_LEN);

	// One division slot per digit that is split off below the lower axis.
	localparam int NUM_SLOTS    = NUM_LEN - 1;
	localparam int BITS_PER_STG = 2;
	localparam int STG_PER_DIV  = INDEX_W / BITS_PER_STG;
	localparam int DIV_STG      = NUM_SLOTS * STG_PER_DIV;
	localparam int MUL_STG      = NUM_SLOTS;
	localparam int TOT_STG      = 1 + DIV_STG + MUL_STG;

	// Configuration register indexes.
	typedef enum logic [SPAN_W-1:0] {
		REG_SPAN  = 3'd0,
		REG_LEN_A = 3'd1,
		REG_LEN_B = 3'd2,
		REG_LEN_C = 3'd3,
		REG_LEN_D = 3'd4,
		REG_LEN_E = 3'd5,
		REG_LEN_F = 3'd6
	} reg_idx_t;

	typedef logic [NUM_SLOTS-1:0][LEN_W-1:0] digits_t;

	// A zero length behaves as length one in the digit arithmetic.
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		eff_len = (len == '0) ? LEN_W'(1) : len;
	endfunction

endpackage

`default_nettype wire

[sv/axis_transpose_index_map_core.sv]
// Pipelined transpose index generator: mixed-radix split and recombination of a line index.
`default_nettype none

// One request enters per cycle while the pipeline advances; its result passes one capture stage,
// 80 stages of radix-4 long division and five multiply-accumulate stages. The division chain
// is the longest part: each of the five digit divisions by a 16-bit axis length retires two
// quotient bits per stage. The pipeline advances as a whole whenever the output register is
// empty or being taken, so throughput is one request per cycle without backpressure. The
// configuration registers feed every stage directly; the user must write them only while the
// pipeline is empty; the block does not enforce this. A zero span length, or a line index at or
// beyond the product of the span lengths, sets out_of_range; source_index then wraps modulo 2^32.
module axis_transpose_index_map_core
	import atim_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [SPAN_W-1:0]  cfg_index,
	input  wire logic [LEN_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [INDEX_W-1:0] line_index,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [INDEX_W-1:0]      source_index,
	output logic                    out_of_range
);

	// Configuration registers.
	logic [SPAN_W-1:0] span_q;
	logic [LEN_W-1:0]  len_q [0:NUM_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_MIN;
			for (int i = 0; i < NUM_LEN; i++) begin
				len_q[i] <= LEN_W'(1);
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SPAN:  span_q   <= cfg_data[SPAN_W-1:0];
				REG_LEN_A: len_q[0] <= cfg_data;
				REG_LEN_B: len_q[1] <= cfg_data;
				REG_LEN_C: len_q[2] <= cfg_data;
				REG_LEN_D: len_q[3] <= cfg_data;
				REG_LEN_E: len_q[4] <= cfg_data;
				REG_LEN_F: len_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped span, effective lengths and the divisor of each slot.
	logic [SPAN_W-1:0] span_k;
	logic [LEN_W-1:0]  leff [0:NUM_LEN-1];
	logic [LEN_W-1:0]  slot_div [0:NUM_SLOTS-1];
	logic              zero_any;

	always_comb begin
		if (span_q < SPAN_MIN) begin
			span_k = SPAN_MIN;
		end else if (span_q > SPAN_MAX) begin
			span_k = SPAN_MAX;
		end else begin
			span_k = span_q;
		end
		zero_any = 1'b0;
		for (int i = 0; i < NUM_LEN; i++) begin
			leff[i] = eff_len(len_q[i]);
			if (SPAN_W'(i) < span_k && len_q[i] == '0) begin
				zero_any = 1'b1;
			end
		end
		// Slot zero splits off the upper axis, later slots the middle axes in order.
		slot_div[0] = leff[span_k - SPAN_W'(1)];
		for (int j = 1; j < NUM_SLOTS; j++) begin
			slot_div[j] = (SPAN_W'(j) < span_k - SPAN_W'(1)) ? leff[j] : LEN_W'(1);
		end
	end

	// Pipeline advance: everything moves unless a finished result is held.
	logic               adv;
	logic [TOT_STG-1:0] vld_s;

	assign adv      = !(vld_s[TOT_STG-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[TOT_STG-2:0], in_valid};
		end
	end

	// Division pipeline storage; index zero is the capture stage.
	logic [INDEX_W-1:0] num_s [0:DIV_STG];
	logic [LEN_W-1:0]   rem_s [0:DIV_STG];
	digits_t            dig_s [0:DIV_STG];

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0] <= line_index;
			rem_s[0] <= '0;
			dig_s[0] <= '0;
		end
	end

	// Radix-4 restoring division, two quotient bits per stage.
	for (genvar t = 1; t <= DIV_STG; t++) begin : g_div
		localparam int  SL    = (t - 1) / STG_PER_DIV;
		localparam bit  FIRST = ((t - 1) % STG_PER_DIV) == 0;
		localparam bit  LAST  = ((t - 1) % STG_PER_DIV) == STG_PER_DIV - 1;

		logic [INDEX_W-1:0] n_nx;
		logic [LEN_W-1:0]   r_nx;
		digits_t            d_nx;

		always_comb begin
			logic [LEN_W:0] rt;
			n_nx = num_s[t-1];
			r_nx = FIRST ? '0 : rem_s[t-1];
			d_nx = dig_s[t-1];
			for (int b = 0; b < BITS_PER_STG; b++) begin
				rt   = {r_nx, n_nx[INDEX_W-1]};
				n_nx = {n_nx[INDEX_W-2:0], 1'b0};
				if (rt >= {1'b0, slot_div[SL]}) begin
					rt      = rt - {1'b0, slot_div[SL]};
					n_nx[0] = 1'b1;
				end
				r_nx = rt[LEN_W-1:0];
			end
			// The remainder of a finished slot is that slot's digit.
			if (LAST) begin
				d_nx[SL] = r_nx;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s[t] <= n_nx;
				rem_s[t] <= r_nx;
				dig_s[t] <= d_nx;
			end
		end
	end

	// Recombination: multiply-accumulate from the slowest source digit down.
	logic [INDEX_W-1:0] mx_s [1:MUL_STG];
	logic [INDEX_W-1:0] mq_s [1:MUL_STG-1];
	digits_t            md_s [1:MUL_STG-1];
	logic               bad_s5;

	for (genvar m = 0; m < MUL_STG - 1; m++) begin : g_mul
		localparam int J = NUM_SLOTS - 1 - m;

		logic [INDEX_W-1:0]       x_in;
		logic [INDEX_W-1:0]       q_in;
		digits_t                  d_in;
		logic [INDEX_W+LEN_W-1:0] prod;

		if (m == 0) begin : g_first
			assign x_in = INDEX_W'(dig_s[DIV_STG][0]);
			assign q_in = num_s[DIV_STG];
			assign d_in = dig_s[DIV_STG];
		end else begin : g_next
			assign x_in = mx_s[m];
			assign q_in = mq_s[m];
			assign d_in = md_s[m];
		end

		assign prod = x_in * slot_div[J];

		always_ff @(posedge clk) begin
			if (adv) begin
				mx_s[m+1] <= prod[INDEX_W-1:0] + INDEX_W'(d_in[J]);
				mq_s[m+1] <= q_in;
				md_s[m+1] <= d_in;
			end
		end
	end

	// Last stage: the lower axis digit is the remaining quotient.
	logic [INDEX_W+LEN_W-1:0] prod_last;

	assign prod_last = mx_s[MUL_STG-1] * leff[0];

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s[MUL_STG] <= prod_last[INDEX_W-1:0] + mq_s[MUL_STG-1];
			bad_s5        <= zero_any || (mq_s[MUL_STG-1] >= INDEX_W'(leff[0]));
		end
	end

	assign out_valid    = vld_s[TOT_STG-1];
	assign source_index = mx_s[MUL_STG];
	assign out_of_range = bad_s5;

	// An accepted request always lands in the capture stage.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[0])
		else $error("accepted request not captured");

	// A held pipeline keeps every valid bit.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("valid bits moved during a hold");

	// The input is held back only by a held result.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A zero length in the span always flags the result.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_any |-> out_of_range)
		else $error("zero length not flagged");

endmodule

`default_nettype wire
